>>> hw/rtl/tdrs_pkg.sv
`default_nettype none
package tdrs_pkg;

    localparam int ADDR_BITS_DEF = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_ADDRESS  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_BYTES   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_COLUMNS  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_ROWS     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_MODE   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT_BASE   = 3'd7;

    localparam logic [6:0] WSTRIDE_SMALL = 7'd36;
    localparam logic [6:0] WSTRIDE_LARGE = 7'd100;
    localparam logic [9:0] WREAD_BYTES   = 10'd36;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_READ  = 5'b00010,
        PH_WAIT  = 5'b00100,
        PH_WRITE = 5'b01000,
        PH_RESET = 5'b10000
    } t_phase;

    typedef struct packed {
        logic start_read;
        logic dram_ack;
        logic clear;
    } t_in;

    typedef struct packed {
        logic        dram_req_valid;
        logic [31:0] dram_req_addr;
        logic [9:0]  dram_req_bytes;
        logic        input_sram_we;
        logic        weight_sram_we;
        logic        sram_mode_out;
        logic        busy_res;
        logic        done_res;
    } t_out;

    typedef struct packed {
        logic [31:0] start_address;
        logic [31:0] dest_address;
        logic [23:0] total_bytes;
        logic [9:0]  image_width;
        logic [7:0]  tile_columns;
        logic [7:0]  tile_rows;
        logic        kernel_mode;
        logic [31:0] weight_base;
    } t_cfg;

endpackage
`default_nettype wire

>>> hw/rtl/tiled_dma_read_sequencer.sv
// A request is captured in the input register, and its result loads into the result
// register when the output register is empty or its result is being taken.
// Throughput: one request per cycle unless the output stalls; one advance per request.
// Reset is synchronous and active low: the sequencer starts in its reset
// phase with all counters, strobes and configuration registers cleared.
`default_nettype none
module tiled_dma_read_sequencer
    import tdrs_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_in                      i_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_out                          o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg cfg;
    t_out result;
    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;
    logic advance;
    logic in_accept;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    tdrs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tdrs_seq_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
`default_nettype wire

>>> hw/rtl/tdrs_cfg_regs.sv
`default_nettype none
module tdrs_cfg_regs
    import tdrs_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                          o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_ADDRESS: r_cfg.start_address <= i_cfg_data;
                CFG_DEST_ADDRESS:  r_cfg.dest_address  <= i_cfg_data;
                CFG_TOTAL_BYTES:   r_cfg.total_bytes   <= i_cfg_data[23:0];
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[9:0];
                CFG_TILE_COLUMNS:  r_cfg.tile_columns  <= i_cfg_data[7:0];
                CFG_TILE_ROWS:     r_cfg.tile_rows     <= i_cfg_data[7:0];
                CFG_KERNEL_MODE:   r_cfg.kernel_mode   <= i_cfg_data[0];
                CFG_WEIGHT_BASE:   r_cfg.weight_base   <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hw/rtl/tdrs_seq_core.sv
`default_nettype none
module tdrs_seq_core
    import tdrs_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire t_in  i_item,
    input  wire t_cfg i_cfg,
    output t_out      o_result
);

    t_phase                r_phase,       n_phase;
    logic [ADDR_BITS-1:0]  r_next_addr,   n_next_addr;
    logic [ADDR_BITS-1:0]  r_tile_base,   n_tile_base;
    logic [23:0]           r_bytes_left,  n_bytes_left;
    logic [16:0]           r_tile_left,   n_tile_left;
    logic [20:0]           r_plane_words, n_plane_words;
    logic                  r_busy,        n_busy;
    logic                  r_done,        n_done;
    logic                  r_in_we,       n_in_we;
    logic                  r_wt_we,       n_wt_we;
    logic                  r_mode,        n_mode;

    logic                  req_valid;
    logic [ADDR_BITS-1:0]  req_addr;
    logic [9:0]            req_bytes;

    logic [ADDR_BITS-1:0]  start_a;
    logic [ADDR_BITS-1:0]  from_a;
    logic [9:0]            col_bytes;
    logic [11:0]           row_step;
    logic [15:0]           tile_prod;
    logic [19:0]           plane_prod;
    logic [6:0]            stride;
    logic [23:0]           have;
    logic                  input_path;
    logic                  first_read;

    assign start_a    = ADDR_BITS'(i_cfg.start_address);
    assign col_bytes  = {i_cfg.tile_rows, 2'b00};
    assign row_step   = {i_cfg.image_width, 2'b00};
    assign tile_prod  = 16'(i_cfg.tile_columns) * 16'(i_cfg.tile_rows);
    assign plane_prod = 20'(i_cfg.image_width) * 20'(i_cfg.image_width);
    assign stride     = i_cfg.kernel_mode ? WSTRIDE_SMALL : WSTRIDE_LARGE;
    assign input_path = i_cfg.dest_address < i_cfg.weight_base;
    assign first_read = r_bytes_left == 24'd0;
    assign from_a     = first_read ? start_a : r_next_addr;
    assign have       = first_read ? i_cfg.total_bytes : r_bytes_left;

    always_comb begin
        n_phase       = r_phase;
        n_next_addr   = r_next_addr;
        n_tile_base   = r_tile_base;
        n_bytes_left  = r_bytes_left;
        n_tile_left   = r_tile_left;
        n_plane_words = r_plane_words;
        n_busy        = r_busy;
        n_done        = r_done;
        n_in_we       = r_in_we;
        n_wt_we       = r_wt_we;
        n_mode        = r_mode;
        req_valid     = 1'b0;
        req_addr      = '0;
        req_bytes     = '0;

        if (i_item.clear) begin
            n_phase = PH_RESET;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_item.start_read) begin
                        n_phase = PH_READ;
                    end
                end
                PH_READ: begin
                    req_valid = 1'b1;
                    n_in_we   = 1'b0;
                    n_wt_we   = 1'b0;
                    n_mode    = 1'b1;
                    n_busy    = 1'b1;
                    n_phase   = PH_WAIT;
                    if (input_path) begin
                        req_bytes    = col_bytes;
                        req_addr     = from_a;
                        // Saturating length countdown by one column.
                        n_bytes_left = (have > 24'(col_bytes))
                                     ? have - 24'(col_bytes) : 24'd0;
                        if (first_read) begin
                            n_next_addr   = start_a + ADDR_BITS'(row_step);
                            n_tile_base   = start_a;
                            n_plane_words = 21'(plane_prod);
                            n_tile_left   = 17'(tile_prod) - 17'(i_cfg.tile_rows);
                        end else if (r_tile_left == 17'(i_cfg.tile_rows)) begin
                            // Last column of a tile: jump to the next tile start.
                            n_tile_left = 17'(tile_prod);
                            n_tile_base = r_tile_base
                                        + ADDR_BITS'({r_plane_words, 2'b00});
                            n_next_addr = r_tile_base
                                        + ADDR_BITS'({r_plane_words, 2'b00});
                        end else begin
                            n_tile_left = r_tile_left - 17'(i_cfg.tile_rows);
                            n_next_addr = r_next_addr + ADDR_BITS'(row_step);
                        end
                    end else begin
                        req_addr     = from_a;
                        req_bytes    = WREAD_BYTES;
                        n_next_addr  = from_a + ADDR_BITS'(stride);
                        n_bytes_left = (have > 24'(stride)) ? have - 24'(stride) : 24'd0;
                    end
                end
                PH_WAIT: begin
                    if (i_item.dram_ack) begin
                        n_phase = PH_WRITE;
                    end
                end
                PH_WRITE: begin
                    n_phase = first_read ? PH_RESET : PH_READ;
                    if (input_path) begin
                        n_in_we = 1'b1;
                    end else begin
                        n_wt_we = 1'b1;
                    end
                    n_mode = i_cfg.kernel_mode;
                    if (first_read) begin
                        n_done = 1'b1;
                    end
                end
                PH_RESET: begin
                    n_phase       = PH_IDLE;
                    n_busy        = 1'b0;
                    n_in_we       = 1'b0;
                    n_wt_we       = 1'b0;
                    n_done        = 1'b0;
                    n_bytes_left  = '0;
                    n_tile_left   = '0;
                    n_plane_words = '0;
                end
                default: begin
                    n_phase = PH_RESET;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_RESET;
            r_next_addr   <= '0;
            r_tile_base   <= '0;
            r_bytes_left  <= '0;
            r_tile_left   <= '0;
            r_plane_words <= '0;
            r_busy        <= 1'b0;
            r_done        <= 1'b0;
            r_in_we       <= 1'b0;
            r_wt_we       <= 1'b0;
            r_mode        <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_next_addr   <= n_next_addr;
            r_tile_base   <= n_tile_base;
            r_bytes_left  <= n_bytes_left;
            r_tile_left   <= n_tile_left;
            r_plane_words <= n_plane_words;
            r_busy        <= n_busy;
            r_done        <= n_done;
            r_in_we       <= n_in_we;
            r_wt_we       <= n_wt_we;
            r_mode        <= n_mode;
        end
    end

    always_comb begin
        o_result.dram_req_valid = req_valid;
        o_result.dram_req_addr  = 32'(req_addr);
        o_result.dram_req_bytes = req_bytes;
        o_result.input_sram_we  = n_in_we;
        o_result.weight_sram_we = n_wt_we;
        o_result.sram_mode_out  = n_mode;
        o_result.busy_res       = n_busy;
        o_result.done_res       = n_done;
    end

endmodule
`default_nettype wire

>>> hw/rtl/tdrs_checker.sv
`default_nettype none
module tdrs_checker
    import tdrs_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     o_in_ready,
    input  wire t_in                      i_in,
    input  wire logic                     o_out_valid,
    input  wire logic                     i_out_ready,
    input  wire t_out                     o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Ticks that issue no DRAM read carry a zero address and length.
    a_idle_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.dram_req_valid |->
            o_out.dram_req_addr == 32'd0 && o_out.dram_req_bytes == 10'd0)
        else $error("request fields set without a read");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.dram_req_valid |->
            o_out.busy_res && !o_out.input_sram_we && !o_out.weight_sram_we)
        else $error("read issued while not busy or with a strobe");

    a_strobe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.input_sram_we && o_out.weight_sram_we))
        else $error("both SRAM strobes high");

endmodule

bind tiled_dma_read_sequencer tdrs_checker u_tdrs_checker (.*);
`default_nettype wire
